FILE: design/satl_pkg.sv
// shared constants, command/status types and helper functions for the cache tag lookup
// no dependencies; imported by satl_ctrl, satl_dp and set_assoc_cache_tag_lookup
`default_nettype none

package satl_pkg;

    // cache geometry
    localparam int WAYS      = 8;
    localparam int SETS      = 64;
    localparam int ADDR_BITS = 34;
    localparam int SET_BITS  = $clog2(SETS);
    localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
    localparam int WAY_BITS  = $clog2(WAYS);

    // victim selection lfsr
    localparam int          LFSR_BITS = 16;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // width of the hit and miss totals
    localparam int CNT_BITS = 32;

    // access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // take the request and read its set row
        logic commit;   // resolve the lookup, update state, load result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_status;

    // one set: per-way valid bits and tags
    typedef struct packed {
        logic [WAYS-1:0]               valid;
        logic [WAYS-1:0][TAG_BITS-1:0] tag;
    } t_row;

    // index of the lowest set bit, zero when none is set
    function automatic logic [WAY_BITS-1:0] first_set(input logic [WAYS-1:0] vec);
        logic [WAY_BITS-1:0] idx;
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vec[w]) begin
                idx = WAY_BITS'(w);
            end
        end
        return idx;
    endfunction

    // one right shift of the lfsr, taps 16,14,13,11
    function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_BITS-1:1]};
    endfunction

endpackage

`default_nettype wire

FILE: design/satl_ctrl.sv
// controller state machine for the cache tag lookup
// depends on satl_pkg for the command and status types
`default_nettype none

module satl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire satl_pkg::t_status i_status,
    output satl_pkg::t_cmd         o_cmd,
    output logic                   o_req_ready
);
    import satl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // commands and next state
    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_capture_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> r_state == S_LOOK)
        else $error("capture did not move controller to lookup");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !i_status.out_free) |=> (r_state == S_LOOK && !$past(cmd.commit)))
        else $error("lookup left while result register busy");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: design/satl_dp.sv
// datapath for the cache tag lookup: set memory, tag compare, fill, lfsr, counters, result
// depends on satl_pkg for geometry, types and helper functions
`default_nettype none

module satl_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire satl_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_func,
    input  wire logic [satl_pkg::ADDR_BITS-1:0]    i_block_address,
    input  wire logic                              i_rsp_ready,
    output satl_pkg::t_status                      o_status,
    output logic                                   o_rsp_valid,
    output logic                                   o_hit,
    output logic [2:0]                             o_way,
    output logic                                   o_filled,
    output logic                                   o_evicted,
    output logic [satl_pkg::CNT_BITS-1:0]          o_hit_total,
    output logic [satl_pkg::CNT_BITS-1:0]          o_miss_total
);
    import satl_pkg::*;

    // set memory, one row per set
    t_row r_mem [SETS];
    // row written at least once since reset
    logic [SETS-1:0] r_row_init;

    // request registers
    logic                r_func;
    logic [SET_BITS-1:0] r_set;
    logic [TAG_BITS-1:0] r_tag;
    t_row                r_rd_row;
    logic                r_rd_init;

    // persistent state
    logic [LFSR_BITS-1:0] r_lfsr;
    logic [CNT_BITS-1:0]  r_hit_cnt;
    logic [CNT_BITS-1:0]  r_miss_cnt;

    // result register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [WAY_BITS-1:0] r_out_way;
    logic                r_out_filled;
    logic                r_out_evicted;

    // lookup logic
    logic [WAYS-1:0]      eff_valid;
    logic [WAYS-1:0]      match;
    logic                 hit;
    logic                 have_free;
    logic                 is_fill;
    logic                 is_evict;
    logic [LFSR_BITS-1:0] lfsr_next;
    logic [WAY_BITS-1:0]  target;
    logic [WAY_BITS-1:0]  way_out;
    t_row                 new_row;

    always_comb begin
        eff_valid = r_rd_row.valid & {WAYS{r_rd_init}};
        for (int w = 0; w < WAYS; w++) begin
            match[w] = eff_valid[w] && (r_rd_row.tag[w] == r_tag);
        end
        hit       = |match;
        have_free = |(~eff_valid);
        lfsr_next = lfsr_step(r_lfsr);
        is_fill   = !hit && (r_func == FUNC_READ);
        is_evict  = is_fill && !have_free;
        target    = have_free ? first_set(~eff_valid) : lfsr_next[WAY_BITS-1:0];
        if (hit) begin
            way_out = first_set(match);
        end else if (is_fill) begin
            way_out = target;
        end else begin
            way_out = '0;
        end
        new_row               = r_rd_row;
        new_row.valid         = eff_valid;
        new_row.valid[target] = 1'b1;
        new_row.tag[target]   = r_tag;
    end

    // request capture, set read and row write
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_set    <= i_block_address[SET_BITS-1:0];
            r_tag    <= i_block_address[ADDR_BITS-1:SET_BITS];
            r_rd_row <= r_mem[i_block_address[SET_BITS-1:0]];
        end
        if (i_cmd.commit && is_fill) begin
            r_mem[r_set] <= new_row;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit     <= hit;
            r_out_way     <= way_out;
            r_out_filled  <= is_fill;
            r_out_evicted <= is_evict;
        end
    end

    // control state: row init flags, lfsr, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init  <= '0;
            r_rd_init   <= 1'b0;
            r_lfsr      <= LFSR_SEED;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_init <= r_row_init[i_block_address[SET_BITS-1:0]];
            end
            if (i_cmd.commit) begin
                if (is_fill) begin
                    r_row_init[r_set] <= 1'b1;
                end
                if (is_evict) begin
                    r_lfsr <= lfsr_next;
                end
                if (hit) begin
                    r_hit_cnt <= (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + 1'b1;
                end else begin
                    r_miss_cnt <= (r_miss_cnt == '1) ? r_miss_cnt : r_miss_cnt + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // totals only change at commit, which needs a free result register,
    // so they always match the result being offered
    assign o_status.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_way             = 3'(r_out_way);
    assign o_filled          = r_out_filled;
    assign o_evicted         = r_out_evicted;
    assign o_hit_total       = r_hit_cnt;
    assign o_miss_total      = r_miss_cnt;

`ifndef SYNTHESIS
    a_fill_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_fill) |-> (!hit && r_func == FUNC_READ))
        else $error("fill on a hit or a write");

    a_evict_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_evict) |-> (eff_valid == '1))
        else $error("eviction while a free way exists");

    a_lfsr_only_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && is_evict) |=> $stable(r_lfsr))
        else $error("lfsr advanced without eviction");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && hit) |=>
            (r_hit_cnt == $past(r_hit_cnt) + 1'b1 || $past(r_hit_cnt) == '1))
        else $error("hit total not advanced on hit");
`endif

endmodule

`default_nettype wire

FILE: design/set_assoc_cache_tag_lookup.sv
// Tag lookup of an 8-way, 64-set cache with random replacement. Accepting a
// request reads the whole set row (eight tags and valid bits) from the set
// memory into a register; then, once the result register is free, the lookup
// compares all ways, fills on a read miss and loads the result register. A new
// request is taken only after the lookup of the previous one has committed.
// A finished result waits in its own register, and a new request is
// accepted while it waits. A per-set flag cleared by reset marks sets never
// written, so no clearing pass runs after reset.
// Depends on satl_pkg, satl_ctrl and satl_dp.
`default_nettype none

module set_assoc_cache_tag_lookup (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire logic                           i_func,
    input  wire logic [satl_pkg::ADDR_BITS-1:0] i_block_address,
    // result channel
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output logic                                o_hit,
    output logic [2:0]                          o_way,
    output logic                                o_filled,
    output logic                                o_evicted,
    output logic [satl_pkg::CNT_BITS-1:0]       o_hit_total,
    output logic [satl_pkg::CNT_BITS-1:0]       o_miss_total
);
    import satl_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller
    satl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_ready (o_req_ready)
    );

    // datapath
    satl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_block_address (i_block_address),
        .i_rsp_ready     (i_rsp_ready),
        .o_status        (status),
        .o_rsp_valid     (o_rsp_valid),
        .o_hit           (o_hit),
        .o_way           (o_way),
        .o_filled        (o_filled),
        .o_evicted       (o_evicted),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total)
    );

endmodule

`default_nettype wire
